// File: rtl/residual_escape_code_encoder_defines.svh
// Assertion macros for the residual escape-code encoder checker.
// No dependencies; include by bare file name.
`ifndef RESIDUAL_ESCAPE_CODE_ENCODER_DEFINES_SVH
`define RESIDUAL_ESCAPE_CODE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define RECEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder check failed");

// Next-cycle implication, disabled in reset
`define RECEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder check failed");

`endif

// File: rtl/recec_pkg.sv
// Package for the residual escape-code encoder: payload types, path codes,
// the per-mode parameter ROM and helper functions. No dependencies.
package recec_pkg;

    localparam int unsigned NUM_ROWS  = 50;
    localparam int unsigned RUN_CAP   = 9;
    localparam int unsigned WIDE_HDR  = 7;
    localparam int unsigned HDR_BITS  = 3;
    localparam int unsigned EXT_BITS  = 5;
    localparam int unsigned ESC_ZEROS = 9;
    localparam int unsigned LOW_W     = 24;
    localparam int unsigned REM_W     = 25;
    localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;

    typedef struct packed {
        logic signed [31:0] residual;
        logic               segment_end;
    } in_t;

    typedef struct packed {
        logic [31:0] chunk_bits;
        logic [5:0]  chunk_length;
        logic        last_chunk;
        logic        segment_done;
    } out_t;

    typedef enum logic [2:0] {
        PATH_NONE,
        PATH_SHORT,
        PATH_FLAG0,
        PATH_FLAG1,
        PATH_UNARY,
        PATH_LONG
    } path_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  w;
        logic [25:0] esc;
        logic [4:0]  shift;
        logic        div3;
        logic [26:0] aesc;
        logic [27:0] off;
    } row_t;

    // Divider request and answer between the top level and the divide unit
    typedef struct packed {
        logic [31:0]      t;
        logic [LOW_W-1:0] low;
        logic [4:0]       shift;
        logic             div3;
    } div_req_t;

    typedef struct packed {
        logic [31:0]      q;
        logic [REM_W-1:0] rem;
    } div_rsp_t;

    // Parameter ROM; divisor is 2^shift, times three when div3 is set
    function automatic row_t rom_row(input logic [5:0] mode);
        row_t r;
        r = '0;
        case (mode)
            6'd1:  r = '{1'b1, 5'h01, 26'h0000001, 5'd0,  1'b0, 27'h0000003, 28'h0000008};
            6'd2:  r = '{1'b1, 5'h02, 26'h0000003, 5'd0,  1'b0, 27'h0000007, 28'h0000006};
            6'd3:  r = '{1'b1, 5'h03, 26'h0000005, 5'd1,  1'b0, 27'h000000E, 28'h000000D};
            6'd4:  r = '{1'b1, 5'h03, 26'h0000003, 5'd0,  1'b1, 27'h000000D, 28'h0000018};
            6'd5:  r = '{1'b1, 5'h04, 26'h000000B, 5'd2,  1'b0, 27'h000001C, 28'h0000019};
            6'd6:  r = '{1'b1, 5'h04, 26'h0000006, 5'd1,  1'b1, 27'h000001A, 28'h0000030};
            6'd7:  r = '{1'b1, 5'h05, 26'h0000016, 5'd3,  1'b0, 27'h0000038, 28'h0000032};
            6'd8:  r = '{1'b1, 5'h05, 26'h000000C, 5'd2,  1'b1, 27'h0000034, 28'h0000060};
            6'd9:  r = '{1'b1, 5'h06, 26'h000002C, 5'd4,  1'b0, 27'h0000070, 28'h0000064};
            6'd10: r = '{1'b1, 5'h06, 26'h0000018, 5'd3,  1'b1, 27'h0000068, 28'h00000C0};
            6'd11: r = '{1'b1, 5'h07, 26'h0000058, 5'd5,  1'b0, 27'h00000E0, 28'h00000C8};
            6'd12: r = '{1'b1, 5'h07, 26'h0000030, 5'd4,  1'b1, 27'h00000D0, 28'h0000180};
            6'd13: r = '{1'b1, 5'h08, 26'h00000B0, 5'd6,  1'b0, 27'h00001C0, 28'h0000190};
            6'd14: r = '{1'b1, 5'h08, 26'h0000060, 5'd5,  1'b1, 27'h00001A0, 28'h0000300};
            6'd15: r = '{1'b1, 5'h09, 26'h0000160, 5'd7,  1'b0, 27'h0000380, 28'h0000320};
            6'd16: r = '{1'b1, 5'h09, 26'h00000C0, 5'd6,  1'b1, 27'h0000340, 28'h0000600};
            6'd17: r = '{1'b1, 5'h0A, 26'h00002C0, 5'd8,  1'b0, 27'h0000700, 28'h0000640};
            6'd18: r = '{1'b1, 5'h0A, 26'h0000180, 5'd7,  1'b1, 27'h0000680, 28'h0000C00};
            6'd19: r = '{1'b1, 5'h0B, 26'h0000580, 5'd9,  1'b0, 27'h0000E00, 28'h0000C80};
            6'd20: r = '{1'b1, 5'h0B, 26'h0000300, 5'd8,  1'b1, 27'h0000D00, 28'h0001800};
            6'd21: r = '{1'b1, 5'h0C, 26'h0000B00, 5'd10, 1'b0, 27'h0001C00, 28'h0001900};
            6'd22: r = '{1'b1, 5'h0C, 26'h0000600, 5'd9,  1'b1, 27'h0001A00, 28'h0003000};
            6'd23: r = '{1'b1, 5'h0D, 26'h0001600, 5'd11, 1'b0, 27'h0003800, 28'h0003200};
            6'd24: r = '{1'b1, 5'h0D, 26'h0000C00, 5'd10, 1'b1, 27'h0003400, 28'h0006000};
            6'd25: r = '{1'b1, 5'h0E, 26'h0002C00, 5'd12, 1'b0, 27'h0007000, 28'h0006400};
            6'd26: r = '{1'b1, 5'h0E, 26'h0001800, 5'd11, 1'b1, 27'h0006800, 28'h000C000};
            6'd27: r = '{1'b1, 5'h0F, 26'h0005800, 5'd13, 1'b0, 27'h000E000, 28'h000C800};
            6'd28: r = '{1'b1, 5'h0F, 26'h0003000, 5'd12, 1'b1, 27'h000D000, 28'h0018000};
            6'd29: r = '{1'b1, 5'h10, 26'h000B000, 5'd14, 1'b0, 27'h001C000, 28'h0019000};
            6'd30: r = '{1'b1, 5'h10, 26'h0006000, 5'd13, 1'b1, 27'h001A000, 28'h0030000};
            6'd31: r = '{1'b1, 5'h11, 26'h0016000, 5'd15, 1'b0, 27'h0038000, 28'h0032000};
            6'd32: r = '{1'b1, 5'h11, 26'h000C000, 5'd14, 1'b1, 27'h0034000, 28'h0060000};
            6'd33: r = '{1'b1, 5'h12, 26'h002C000, 5'd16, 1'b0, 27'h0070000, 28'h0064000};
            6'd34: r = '{1'b1, 5'h12, 26'h0018000, 5'd15, 1'b1, 27'h0068000, 28'h00C0000};
            6'd35: r = '{1'b1, 5'h13, 26'h0058000, 5'd17, 1'b0, 27'h00E0000, 28'h00C8000};
            6'd36: r = '{1'b1, 5'h13, 26'h0030000, 5'd16, 1'b1, 27'h00D0000, 28'h0180000};
            6'd37: r = '{1'b1, 5'h14, 26'h00B0000, 5'd18, 1'b0, 27'h01C0000, 28'h0190000};
            6'd38: r = '{1'b1, 5'h14, 26'h0060000, 5'd17, 1'b1, 27'h01A0000, 28'h0300000};
            6'd39: r = '{1'b1, 5'h15, 26'h0160000, 5'd19, 1'b0, 27'h0380000, 28'h0320000};
            6'd40: r = '{1'b1, 5'h15, 26'h00C0000, 5'd18, 1'b1, 27'h0340000, 28'h0600000};
            6'd41: r = '{1'b1, 5'h16, 26'h02C0000, 5'd20, 1'b0, 27'h0700000, 28'h0640000};
            6'd42: r = '{1'b1, 5'h16, 26'h0180000, 5'd19, 1'b1, 27'h0680000, 28'h0C00000};
            6'd43: r = '{1'b1, 5'h17, 26'h0580000, 5'd21, 1'b0, 27'h0E00000, 28'h0C80000};
            6'd44: r = '{1'b1, 5'h17, 26'h0300000, 5'd20, 1'b1, 27'h0D00000, 28'h1800000};
            6'd45: r = '{1'b1, 5'h18, 26'h0B00000, 5'd22, 1'b0, 27'h1C00000, 28'h1900000};
            6'd46: r = '{1'b1, 5'h18, 26'h0600000, 5'd21, 1'b1, 27'h1A00000, 28'h3000000};
            6'd47: r = '{1'b1, 5'h19, 26'h1600000, 5'd23, 1'b0, 27'h3800000, 28'h3200000};
            6'd48: r = '{1'b1, 5'h19, 26'h0C00000, 5'd22, 1'b1, 27'h3400000, 28'h6000000};
            6'd49: r = '{1'b1, 5'h1A, 26'h2C00000, 5'd24, 1'b0, 27'h7000000, 28'h6400000};
            6'd50: r = '{1'b1, 5'h1A, 26'h1800000, 5'd23, 1'b1, 27'h6800000, 28'hC000000};
            default: r = '0;
        endcase
        return r;
    endfunction

    // Bit width of a word, at least one
    function automatic logic [5:0] bit_width(input logic [31:0] s);
        logic [5:0] b;
        b = 6'd1;
        for (int i = 1; i < 32; i++) begin
            if (s[i]) b = 6'(i + 1);
        end
        return b;
    endfunction

endpackage

// File: rtl/recec_div.sv
// Divide unit of the encoder: splits a value by 2^shift or 3*2^shift.
// One register stage on the reciprocal product. Depends on recec_pkg.
module recec_div (
    input  logic                clk,
    input  logic                adv,
    input  recec_pkg::div_req_t req,
    output recec_pkg::div_rsp_t rsp
);
    import recec_pkg::*;

    logic [63:0]      prod;
    logic [30:0]      q3_reg;
    logic [31:0]      t_reg;
    logic [LOW_W-1:0] low_reg;
    logic [4:0]       shift_reg;
    logic             div3_reg;
    logic [31:0]      q3;
    logic [1:0]       r3;
    logic [REM_W-1:0] r3_sh;

    // Multiply by the reciprocal of three
    assign prod = 64'(req.t) * 64'(RECIP3);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q3_reg    <= prod[63:33];
            t_reg     <= req.t;
            low_reg   <= req.low;
            shift_reg <= req.shift;
            div3_reg  <= req.div3;
        end
    end

    // Recover the residue mod three from the low bits alone
    always_comb
    begin
        q3    = {1'b0, q3_reg};
        r3    = t_reg[1:0] - 2'(q3[1:0] * 2'd3);
        r3_sh = REM_W'(r3) << shift_reg;
        if (div3_reg)
        begin
            rsp.q   = q3;
            rsp.rem = REM_W'(low_reg) + r3_sh;
        end
        else
        begin
            rsp.q   = t_reg;
            rsp.rem = REM_W'(low_reg);
        end
    end

endmodule

// File: rtl/residual_escape_code_encoder.sv
// Top level of the residual escape-code encoder: pipeline and chunk emitter.
// Depends on recec_pkg and recec_div.
//
// A residual is taken when start is high and busy is low. Its first chunk is
// strobed on rsp after the four register stages (input, divide, first chunk,
// emit). The code word goes out as one to three chunks, one chunk per cycle,
// each marked by strobe for exactly one cycle; results cannot be held off.
// Codes of one chunk sustain one residual per cycle. A code of more chunks
// holds busy high until the emitter drives its final chunk, so the input rate
// is set by the single-chunk-per-cycle output port. Mode 0 or above 50 emits
// nothing.
// Write code_mode through cfg only while no residual is in flight.
module residual_escape_code_encoder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  recec_pkg::in_t  req,
    output logic            strobe,
    output recec_pkg::out_t rsp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [5:0]      cfg_data
);
    import recec_pkg::*;

    logic       adv;
    logic       stall;
    logic [5:0] code_mode_reg;

    // Input stage
    logic        i_valid_reg;
    logic [31:0] i_res_reg;
    logic        i_seg_reg;
    logic [5:0]  i_mode_reg;

    // Stage A: path select
    row_t        row;
    logic [31:0] x;
    logic [32:0] x_esc;
    logic [32:0] a_off;
    logic [31:0] mask32;
    logic [31:0] val;
    path_t       a_path_next;
    logic [31:0] a_bits_next;
    logic [5:0]  a_len_next;
    div_req_t    div_req;

    // Stage B: division in flight
    logic        b_valid_reg;
    logic        b_seg_reg;
    path_t       b_path_reg;
    logic [31:0] b_bits_reg;
    logic [5:0]  b_len_reg;
    logic [4:0]  b_w_reg;
    logic [26:0] b_aesc_reg;
    div_rsp_t    div_rsp;

    // Stage C: quotient and first chunk
    logic [27:0] base_sum;
    logic [26:0] mask27;
    logic [26:0] base;
    logic        c_valid_reg;
    logic        c_seg_reg;
    path_t       c_path_reg;
    logic [31:0] c_bits_reg;
    logic [5:0]  c_len_reg;
    logic [31:0] c_q_reg;
    logic [31:0] c_bits_next;
    logic [5:0]  c_len_next;

    // Emit stage
    logic [31:0] s;
    logic [5:0]  b;
    logic [1:0]  e_n_next;
    logic [31:0] e_bits_next [3];
    logic [5:0]  e_len_next [3];
    logic        e_valid_reg;
    logic [1:0]  e_n_reg;
    logic [1:0]  e_idx_reg;
    logic        e_seg_reg;
    logic [31:0] e_bits_reg [3];
    logic [5:0]  e_len_reg [3];
    logic        e_last;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_mode_reg <= '0;
        else if (cfg_valid && cfg_ready)
            code_mode_reg <= cfg_data;
    end

    // Hold the whole pipe while the emitter drains extra chunks
    assign e_last = ({1'b0, e_idx_reg} + 3'd1) >= {1'b0, e_n_reg};
    assign stall  = e_valid_reg && !e_last;
    assign adv    = !stall;
    assign busy   = stall;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            e_idx_reg   <= '0;
        end
        else if (adv)
        begin
            i_valid_reg <= start;
            b_valid_reg <= i_valid_reg;
            c_valid_reg <= b_valid_reg;
            e_valid_reg <= c_valid_reg;
            e_idx_reg   <= '0;
        end
        else
        begin
            e_idx_reg <= e_idx_reg + 2'd1;
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_res_reg  <= req.residual;
            i_seg_reg  <= req.segment_end;
            i_mode_reg <= code_mode_reg;
        end
    end

    // Zigzag map, pick the code path, form the simple chunk
    always_comb
    begin
        row         = rom_row(i_mode_reg);
        x           = {i_res_reg[30:0], 1'b0} ^ {32{i_res_reg[31]}};
        mask32      = ~(32'hFFFF_FFFF << row.w);
        x_esc       = {1'b0, x} + 33'(row.esc);
        a_off       = 33'(row.aesc) + 33'(row.off);
        val         = 32'(x_esc - 33'(row.aesc));
        a_path_next = PATH_UNARY;
        a_bits_next = '0;
        a_len_next  = 6'(row.w) + 6'd1;
        if (!row.ok)
            a_path_next = PATH_NONE;
        else if (x < 32'(row.esc))
        begin
            a_path_next = PATH_SHORT;
            a_bits_next = x;
            a_len_next  = 6'(row.w);
        end
        else if ((x >> row.w) == 32'd0)
        begin
            a_path_next = PATH_FLAG0;
            a_bits_next = {x[30:0], 1'b0};
        end
        else if (x_esc < 33'(row.aesc))
        begin
            a_path_next = PATH_FLAG1;
            a_bits_next = {x_esc[30:0] & mask32[30:0], 1'b1};
        end
        else if ({1'b0, x} >= a_off)
        begin
            a_path_next = PATH_LONG;
            val         = 32'({1'b0, x} - a_off);
        end
        div_req.t     = val >> row.shift;
        div_req.low   = LOW_W'(val & ~(32'hFFFF_FFFF << row.shift));
        div_req.shift = row.shift;
        div_req.div3  = row.div3;
    end

    recec_div u_div (
        .clk (clk),
        .adv (adv),
        .req (div_req),
        .rsp (div_rsp)
    );

    // Carry the side data along the divider
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_seg_reg  <= i_seg_reg;
            b_path_reg <= a_path_next;
            b_bits_reg <= a_bits_next;
            b_len_reg  <= a_len_next;
            b_w_reg    <= row.w;
            b_aesc_reg <= row.aesc;
        end
    end

    // Build the first chunk of the escape paths
    always_comb
    begin
        mask27   = ~(27'h7FF_FFFF << b_w_reg);
        base_sum = 28'(b_aesc_reg) + 28'(div_rsp.rem);
        base     = base_sum[26:0] & mask27;
        if (b_path_reg == PATH_UNARY || b_path_reg == PATH_LONG)
        begin
            c_bits_next = {4'd0, base, 1'b1};
            c_len_next  = 6'(b_w_reg) + 6'd1;
        end
        else
        begin
            c_bits_next = b_bits_reg;
            c_len_next  = b_len_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_seg_reg  <= b_seg_reg;
            c_path_reg <= b_path_reg;
            c_bits_reg <= c_bits_next;
            c_len_reg  <= c_len_next;
            c_q_reg    <= div_rsp.q;
        end
    end

    // Form the run and escape chunks
    always_comb
    begin
        s              = c_q_reg - 32'd1;
        b              = bit_width(s);
        e_bits_next[0] = c_bits_reg;
        e_len_next[0]  = c_len_reg;
        e_bits_next[1] = '0;
        e_len_next[1]  = 6'(ESC_ZEROS + HDR_BITS);
        e_bits_next[2] = s;
        e_len_next[2]  = b;
        case (c_path_reg)
            PATH_NONE:
                e_n_next = 2'd0;
            PATH_UNARY:
            begin
                e_n_next = 2'd2;
                if (c_q_reg < 32'(RUN_CAP))
                begin
                    e_bits_next[1] = 32'd1;
                    e_len_next[1]  = 6'(c_q_reg) + 6'd1;
                end
                else
                    e_len_next[1] = 6'(RUN_CAP);
            end
            PATH_LONG:
            begin
                if (c_q_reg == 32'd0)
                    e_n_next = 2'd2;
                else
                begin
                    e_n_next = 2'd3;
                    if (b >= 6'(WIDE_HDR))
                    begin
                        e_bits_next[1] = (32'(WIDE_HDR) << EXT_BITS)
                                         | 32'(b - 6'(WIDE_HDR));
                        e_len_next[1]  = 6'(ESC_ZEROS + HDR_BITS + EXT_BITS);
                    end
                    else
                        e_bits_next[1] = 32'(b);
                end
            end
            default:
                e_n_next = 2'd1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_n_reg   <= e_n_next;
            e_seg_reg <= c_seg_reg;
            for (int i = 0; i < 3; i++)
            begin
                e_bits_reg[i] <= e_bits_next[i];
                e_len_reg[i]  <= e_len_next[i];
            end
        end
    end

    // Drive one chunk per cycle
    assign strobe           = e_valid_reg && (e_n_reg != 2'd0);
    assign rsp.chunk_bits   = e_bits_reg[e_idx_reg];
    assign rsp.chunk_length = e_len_reg[e_idx_reg];
    assign rsp.last_chunk   = e_last;
    assign rsp.segment_done = e_last && e_seg_reg;

endmodule

// File: rtl/recec_checker.sv
// Port-level checker for the residual escape-code encoder, with its bind.
// Depends on recec_pkg and residual_escape_code_encoder_defines.svh.
`include "residual_escape_code_encoder_defines.svh"

module recec_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            busy,
    input logic            strobe,
    input recec_pkg::out_t rsp
);
    import recec_pkg::*;

    // Busy only while a non-final chunk goes out
    `RECEC_ASSERT_NOW(a_busy_chunk, clk, rst_n, busy, strobe && !rsp.last_chunk)
    // Chunks of one code come back to back
    `RECEC_ASSERT_NEXT(a_chunk_run, clk, rst_n, strobe && !rsp.last_chunk, strobe)
    // Chunk lengths stay in range
    `RECEC_ASSERT_NOW(a_len_range, clk, rst_n, strobe, rsp.chunk_length != 6'd0 && rsp.chunk_length <= 6'd32)
    // Segment end rides on the final chunk only
    `RECEC_ASSERT_NOW(a_seg_last, clk, rst_n, strobe && rsp.segment_done, rsp.last_chunk)

endmodule

bind residual_escape_code_encoder recec_checker u_recec_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for residual_escape_code_encoder: predicts the chunk
// stream of each residual and compares it with the strobed output.
// Depends on recec_pkg and the encoder RTL.
module testbench;
    import recec_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 12;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_t        req;
    logic       strobe;
    out_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [5:0] cfg_data;

    in_t        pending_residuals[$];
    out_t       expected_chunks[$];
    logic [5:0] active_mode;
    int unsigned sender_idle_pct;
    int unsigned error_count;
    int unsigned quiet_cycles;
    bit         hold_sender;

    residual_escape_code_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .strobe    (strobe),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Row parameters of one mode: width, escape, divisor, aescape, bias
    function automatic void mode_params(input logic [5:0] mode, output longint unsigned w,
        output longint unsigned esc, output longint unsigned dv,
        output longint unsigned aesc, output longint unsigned bias);
        int unsigned k;
        int unsigned pair;
        k    = mode - 1;
        pair = k / 2;
        if (pair == 0)
        begin
            // The first two rows follow no pattern
            w    = k + 1;
            esc  = (k == 0) ? 1 : 3;
            dv   = 1;
            aesc = (k == 0) ? 3 : 7;
            bias = (k == 0) ? 8 : 6;
        end
        else if (k % 2 == 0)
        begin
            w    = pair + 2;
            esc  = (pair == 1) ? 5 : 64'd11 << (pair - 2);
            dv   = 64'd1 << pair;
            aesc = 64'd7 << pair;
            bias = (pair == 1) ? 13 : 64'd25 << (pair - 2);
        end
        else
        begin
            w    = pair + 2;
            esc  = 64'd3 << (pair - 1);
            dv   = 64'd3 << (pair - 1);
            aesc = 64'd13 << (pair - 1);
            bias = 64'd24 << (pair - 1);
        end
    endfunction

    // Predict the chunks of one residual under the current mode
    function automatic void encode_residual(input in_t item);
        longint unsigned w, esc, dv, aesc, bias, x, mask, val, q, s, b, base;
        logic [31:0] r;
        out_t c[3];
        int n;
        if (active_mode == 6'd0 || active_mode > 6'd50)
            return;
        mode_params(active_mode, w, esc, dv, aesc, bias);
        r    = item.residual;
        x    = {32'd0, (r << 1) ^ {32{r[31]}}};
        mask = (64'd1 << w) - 1;
        c[0] = '0; c[1] = '0; c[2] = '0;
        if (x < esc)
        begin
            c[0].chunk_bits = 32'(x); c[0].chunk_length = 6'(w); n = 1;
        end
        else if (x < (64'd1 << w))
        begin
            c[0].chunk_bits = 32'(x << 1); c[0].chunk_length = 6'(w + 1); n = 1;
        end
        else if (x + esc < aesc)
        begin
            c[0].chunk_bits = 32'((((x + esc) & mask) << 1) | 1);
            c[0].chunk_length = 6'(w + 1); n = 1;
        end
        else
        begin
            val = (x >= aesc + bias) ? x - bias - aesc : x + esc - aesc;
            q = val / dv;
            base = (aesc + val % dv) & mask;
            c[0].chunk_bits = 32'((base << 1) | 1); c[0].chunk_length = 6'(w + 1);
            if (x < aesc + bias)
            begin
                c[1].chunk_bits = (q < RUN_CAP) ? 32'd1 : 32'd0;
                c[1].chunk_length = (q < RUN_CAP) ? 6'(q + 1) : 6'(RUN_CAP);
                n = 2;
            end
            else if (q == 0)
            begin
                c[1].chunk_length = 6'(ESC_ZEROS + HDR_BITS); n = 2;
            end
            else
            begin
                s = q - 1;
                b = 1;
                while (b < 32 && (64'd1 << b) <= s)
                    b++;
                if (b >= WIDE_HDR)
                begin
                    c[1].chunk_bits = 32'((WIDE_HDR << EXT_BITS) | (b - WIDE_HDR));
                    c[1].chunk_length = 6'(ESC_ZEROS + HDR_BITS + EXT_BITS);
                end
                else
                begin
                    c[1].chunk_bits = 32'(b);
                    c[1].chunk_length = 6'(ESC_ZEROS + HDR_BITS);
                end
                c[2].chunk_bits = 32'(s); c[2].chunk_length = 6'(b); n = 3;
            end
        end
        c[n-1].last_chunk = 1'b1;
        c[n-1].segment_done = item.segment_end;
        for (int i = 0; i < n; i++)
            expected_chunks.push_back(c[i]);
    endfunction

    // Drive residuals from the pending queue and predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            if (start && !busy)
                encode_residual(req);
            if (!(start && busy))
            begin
                if (pending_residuals.size() != 0 && !hold_sender &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    start <= 1'b1;
                    req   <= pending_residuals.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Compare each strobed chunk with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_chunks.size() == 0)
            begin
                $display("%0t: unexpected chunk %p", $realtime, rsp);
                error_count++;
            end
            else if (rsp !== expected_chunks[0])
            begin
                $display("%0t: mismatch expected %p actual %p", $realtime,
                    expected_chunks[0], rsp);
                error_count++;
                void'(expected_chunks.pop_front());
            end
            else
                void'(expected_chunks.pop_front());
        end
    end

    // Watchdog: count cycles without any accepted request or chunk
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || (cfg_valid && cfg_ready) ||
            (pending_residuals.size() == 0 && expected_chunks.size() == 0 && !start))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_residuals.size() != 0 || start || expected_chunks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [5:0] mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        active_mode = mode;
        @(posedge clk);
    endtask

    function automatic in_t random_residual();
        in_t item;
        int unsigned sel;
        sel = $urandom_range(9);
        item.segment_end = 1'($urandom_range(1));
        if (sel < 5)
            item.residual = $signed($urandom_range(64)) - 32;
        else if (sel < 8)
            item.residual = $signed($urandom) >>> $urandom_range(31);
        else
            item.residual = $urandom;
        return item;
    endfunction

    // Phases of modes and idle patterns
    initial
    begin
        logic [5:0] modes[10];
        int unsigned idles[4];
        in_t item;
        modes = '{6'd1, 6'd50, 6'd0, 6'd2, 6'd49, 6'd63, 6'd17, 6'd51, 6'd4, 6'd30};
        idles = '{0, 75, 12, 0};
        rst_n = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
        active_mode = '0; sender_idle_pct = 0; error_count = 0;
        quiet_cycles = 0; hold_sender = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes and small residuals in the smallest and largest modes
        foreach (modes[m])
        begin
            write_mode(modes[m]);
            begin
                int signed dir[8];
                dir = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 5, -9, 40};
                if (m < 2)
                    foreach (dir[j])
                    begin
                        item.residual = dir[j];
                        item.segment_end = j[0];
                        pending_residuals.push_back(item);
                    end
            end
            sender_idle_pct = idles[m % 4];
            for (int k = 0; k < 33; k++)
                pending_residuals.push_back(random_residual());
            if (m == 3)
            begin
                // Pause the sender until every expected chunk is back
                repeat (20) @(posedge clk);
                hold_sender = 1'b1;
                while (start || expected_chunks.size() != 0)
                    @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end
        // Random modes for the rest
        for (int p = 0; p < 2; p++)
        begin
            write_mode(6'($urandom_range(1, 50)));
            sender_idle_pct = idles[$urandom_range(3)];
            for (int k = 0; k < 10; k++)
                pending_residuals.push_back(random_residual());
            wait_drained();
        end
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
